// File: hw/rtl/amf3_pkg.sv
// ----------------------------------------------------------------------------
// AMF3 encoder package
// Shared types and constants for the AMF3 scalar value encoder.
// ----------------------------------------------------------------------------
package amf3_pkg;

   localparam int unsigned QUEUE_DEPTH = 2;
   localparam int unsigned JOB_BYTES   = 10;

   localparam logic [3:0] OP_UNDEF   = 4'd0;
   localparam logic [3:0] OP_NULL    = 4'd1;
   localparam logic [3:0] OP_FALSE   = 4'd2;
   localparam logic [3:0] OP_TRUE    = 4'd3;
   localparam logic [3:0] OP_INT     = 4'd4;
   localparam logic [3:0] OP_DOUBLE  = 4'd5;
   localparam logic [3:0] OP_DATE    = 4'd6;
   localparam logic [3:0] OP_STRING  = 4'd7;
   localparam logic [3:0] OP_XMLDOC  = 4'd8;
   localparam logic [3:0] OP_XML     = 4'd9;
   localparam logic [3:0] OP_BYTEARR = 4'd10;
   localparam logic [3:0] OP_PAYLOAD = 4'd11;

   localparam logic [7:0] MK_INT     = 8'h04;
   localparam logic [7:0] MK_DOUBLE  = 8'h05;
   localparam logic [7:0] MK_STRING  = 8'h06;
   localparam logic [7:0] MK_XMLDOC  = 8'h07;
   localparam logic [7:0] MK_DATE    = 8'h08;
   localparam logic [7:0] MK_XML     = 8'h0B;
   localparam logic [7:0] MK_BYTEARR = 8'h0C;
   localparam logic [7:0] DATE_FLAG  = 8'h01;

   localparam logic [63:0] U29_MAX     = 64'h0000_0000_1FFF_FFFF;
   localparam logic [63:0] STR_LEN_MAX = 64'h0000_0000_0FFF_FFFF;
   localparam logic [28:0] U29_LIM1    = 29'h0000_007F;
   localparam logic [28:0] U29_LIM2    = 29'h0000_3FFF;
   localparam logic [28:0] U29_LIM3    = 29'h001F_FFFF;

   typedef struct packed {
      logic [3:0]  opcode;
      logic [63:0] value;
      logic [7:0]  payload_byte;
   } req_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       last;
      logic       error;
   } rsp_type;

   typedef struct packed {
      logic [JOB_BYTES-1:0][7:0] bytes;
      logic [3:0]                count;
      logic                      last;
      logic                      error;
   } job_type;

endpackage

// File: hw/rtl/amf3_front.sv
// ----------------------------------------------------------------------------
// AMF3 front end
// Classifies each input word, tracks string body bytes still due and builds
// a job holding every byte that the word produces.
// ----------------------------------------------------------------------------
module amf3_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  amf3_pkg::req_type req_data,
   output logic              job_valid,
   input  logic              job_ready,
   output amf3_pkg::job_type job_data
);

   logic [27:0]       remaining_ff;
   logic [27:0]       remaining_in;
   logic [28:0]       u29_val;
   logic [3:0][7:0]   u29_bytes;
   logic [3:0]        u29_count;
   logic [27:0]       rem_dec;
   amf3_pkg::job_type job;
   logic              accept;

   assign accept    = req_valid && job_ready;
   assign req_ready = job_ready;
   assign job_valid = req_valid;
   assign job_data  = job;
   assign rem_dec   = remaining_ff - 28'd1;

   always_comb begin
      if (req_data.opcode == amf3_pkg::OP_INT) begin
         u29_val = req_data.value[28:0];
      end else begin
         u29_val = {req_data.value[27:0], 1'b1};
      end
   end

   always_comb begin
      u29_bytes = '0;
      priority if (u29_val <= amf3_pkg::U29_LIM1) begin
         u29_bytes[0] = {1'b0, u29_val[6:0]};
         u29_count    = 4'd1;
      end else if (u29_val <= amf3_pkg::U29_LIM2) begin
         u29_bytes[0] = {1'b1, u29_val[13:7]};
         u29_bytes[1] = {1'b0, u29_val[6:0]};
         u29_count    = 4'd2;
      end else if (u29_val <= amf3_pkg::U29_LIM3) begin
         u29_bytes[0] = {1'b1, u29_val[20:14]};
         u29_bytes[1] = {1'b1, u29_val[13:7]};
         u29_bytes[2] = {1'b0, u29_val[6:0]};
         u29_count    = 4'd3;
      end else begin
         u29_bytes[0] = {1'b1, u29_val[28:22]};
         u29_bytes[1] = {1'b1, u29_val[21:15]};
         u29_bytes[2] = {1'b1, u29_val[14:8]};
         u29_bytes[3] = u29_val[7:0];
         u29_count    = 4'd4;
      end
   end

   always_comb begin
      job          = '0;
      job.count    = 4'd1;
      remaining_in = remaining_ff;
      if (req_data.opcode == amf3_pkg::OP_PAYLOAD) begin
         if (remaining_ff == 28'd0) begin
            job.error = 1'b1;
         end else begin
            job.bytes[0] = req_data.payload_byte;
            job.last     = (rem_dec == 28'd0);
            remaining_in = rem_dec;
         end
      end else if (req_data.opcode > amf3_pkg::OP_PAYLOAD || remaining_ff != 28'd0) begin
         job.error = 1'b1;
      end else begin
         unique case (req_data.opcode)
            amf3_pkg::OP_UNDEF, amf3_pkg::OP_NULL,
            amf3_pkg::OP_FALSE, amf3_pkg::OP_TRUE: begin
               job.bytes[0] = {4'd0, req_data.opcode};
               job.last     = 1'b1;
            end
            amf3_pkg::OP_INT: begin
               if (req_data.value > amf3_pkg::U29_MAX) begin
                  job.error = 1'b1;
               end else begin
                  job.bytes[0]   = amf3_pkg::MK_INT;
                  job.bytes[4:1] = u29_bytes;
                  job.count      = u29_count + 4'd1;
                  job.last       = 1'b1;
               end
            end
            amf3_pkg::OP_DOUBLE: begin
               job.bytes[0] = amf3_pkg::MK_DOUBLE;
               for (int i = 0; i < 8; i++) begin
                  job.bytes[1+i] = req_data.value[63-8*i -: 8];
               end
               job.count = 4'd9;
               job.last  = 1'b1;
            end
            amf3_pkg::OP_DATE: begin
               job.bytes[0] = amf3_pkg::MK_DATE;
               job.bytes[1] = amf3_pkg::DATE_FLAG;
               for (int i = 0; i < 8; i++) begin
                  job.bytes[2+i] = req_data.value[63-8*i -: 8];
               end
               job.count = 4'd10;
               job.last  = 1'b1;
            end
            default: begin
               if (req_data.value > amf3_pkg::STR_LEN_MAX) begin
                  job.error = 1'b1;
               end else begin
                  unique case (req_data.opcode)
                     amf3_pkg::OP_STRING: job.bytes[0] = amf3_pkg::MK_STRING;
                     amf3_pkg::OP_XMLDOC: job.bytes[0] = amf3_pkg::MK_XMLDOC;
                     amf3_pkg::OP_XML:    job.bytes[0] = amf3_pkg::MK_XML;
                     default:             job.bytes[0] = amf3_pkg::MK_BYTEARR;
                  endcase
                  job.bytes[4:1] = u29_bytes;
                  job.count      = u29_count + 4'd1;
                  job.last       = (req_data.value[27:0] == 28'd0);
                  remaining_in   = req_data.value[27:0];
               end
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         remaining_ff <= '0;
      end else if (accept) begin
         remaining_ff <= remaining_in;
      end
   end

endmodule

// File: hw/rtl/amf3_queue.sv
// ----------------------------------------------------------------------------
// AMF3 job queue
// Short first-in first-out buffer between the front end and the byte emitter.
// ----------------------------------------------------------------------------
module amf3_queue #(
   parameter int unsigned DEPTH = amf3_pkg::QUEUE_DEPTH
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push_valid,
   output logic              push_ready,
   input  amf3_pkg::job_type push_data,
   output logic              pop_valid,
   input  logic              pop_ready,
   output amf3_pkg::job_type pop_data
);

   localparam int unsigned PTR_W = $clog2(DEPTH);
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

   amf3_pkg::job_type entries_ff [DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff;
   logic [PTR_W-1:0]  wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff;
   logic [PTR_W-1:0]  rd_ptr_in;
   logic [CNT_W-1:0]  count_ff;
   logic [CNT_W-1:0]  count_in;
   logic              push;
   logic              pop;

   assign push_ready = (count_ff != CNT_FULL);
   assign pop_valid  = (count_ff != '0);
   assign pop_data   = entries_ff[rd_ptr_ff];
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_data;
      end
   end

   a_no_overfill: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_FULL)
      else $error("queue holds more words than its depth");

   a_push_grows: assert property (@(posedge clock) disable iff (reset)
      push && !pop |=> count_ff == $past(count_ff) + 1'b1)
      else $error("queue count did not grow on push");

   a_pop_shrinks: assert property (@(posedge clock) disable iff (reset)
      pop && !push |=> count_ff == $past(count_ff) - 1'b1)
      else $error("queue count did not shrink on pop");

endmodule

// File: hw/rtl/amf3_emit.sv
// ----------------------------------------------------------------------------
// AMF3 byte emitter
// Walks the bytes of the job at the queue head, one per cycle while the
// receiver does not stall, into the registered result stage.
// ----------------------------------------------------------------------------
module amf3_emit (
   input  logic              clock,
   input  logic              reset,
   input  logic              job_valid,
   output logic              job_ready,
   input  amf3_pkg::job_type job_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output amf3_pkg::rsp_type rsp_data
);

   logic [3:0]        idx_ff;
   logic [3:0]        idx_in;
   logic              rsp_valid_ff;
   logic              rsp_valid_in;
   amf3_pkg::rsp_type rsp_ff;
   amf3_pkg::rsp_type rsp_in;
   logic              load;
   logic              final_byte;

   assign load       = job_valid && (!rsp_valid_ff || rsp_ready);
   assign final_byte = (idx_ff == job_data.count - 4'd1);
   assign job_ready  = load && final_byte;
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_data   = rsp_ff;

   always_comb begin
      idx_in       = idx_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      if (load) begin
         rsp_in.out_byte = job_data.bytes[idx_ff];
         rsp_in.last     = job_data.last && final_byte;
         rsp_in.error    = job_data.error;
         rsp_valid_in    = 1'b1;
         idx_in          = final_byte ? 4'd0 : idx_ff + 4'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   a_idx_in_job: assert property (@(posedge clock) disable iff (reset)
      job_valid |-> idx_ff < job_data.count)
      else $error("byte index beyond job length");

   a_pop_rewinds: assert property (@(posedge clock) disable iff (reset)
      job_ready |=> idx_ff == 4'd0)
      else $error("byte index not rewound after job");

   a_error_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.error |-> rsp_ff.out_byte == 8'd0 && !rsp_ff.last)
      else $error("error word carries data");

endmodule

// File: hw/rtl/amf3_scalar_value_encoder.sv
// ----------------------------------------------------------------------------
// AMF3 scalar value encoder
// Turns header and payload words into an AMF3 byte stream.
//
// req_* carries one word per handshake: a header (opcode 0..10) starts a
// value, a payload word (opcode 11) carries one string body byte.
// rsp_* carries one stream byte per word; last marks the final byte of a
// value, error flags a word out of range or out of turn (byte zero).
// A word is registered in a queue entry, and each of its bytes then in the
// result stage. The output gives one byte per cycle while rsp_ready is
// high; the emitter steps through the job at the queue head, which holds
// 1 to 10 bytes for a header and one for a payload word.
// A job queue of QUEUE_DEPTH entries sits between the front end and the
// emitter, so the input keeps flowing while the emitter works.
// Reset clears the string byte count, the queue and the result stage.
// When rsp_ready is low the result is held, the emitter stops and the
// input stalls once the queue is full.
// ----------------------------------------------------------------------------
module amf3_scalar_value_encoder #(
   parameter int unsigned QUEUE_DEPTH = amf3_pkg::QUEUE_DEPTH
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  amf3_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output amf3_pkg::rsp_type rsp_data
);

   logic              fq_valid;
   logic              fq_ready;
   amf3_pkg::job_type fq_data;
   logic              qe_valid;
   logic              qe_ready;
   amf3_pkg::job_type qe_data;

   amf3_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .job_valid (fq_valid),
      .job_ready (fq_ready),
      .job_data  (fq_data)
   );

   amf3_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (fq_valid),
      .push_ready (fq_ready),
      .push_data  (fq_data),
      .pop_valid  (qe_valid),
      .pop_ready  (qe_ready),
      .pop_data   (qe_data)
   );

   amf3_emit u_emit (
      .clock     (clock),
      .reset     (reset),
      .job_valid (qe_valid),
      .job_ready (qe_ready),
      .job_data  (qe_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

// File: bench/amf3_scalar_value_encoder_tb.sv
// ----------------------------------------------------------------------------
// AMF3 scalar value encoder testbench
// Sends header and payload words through the encoder and compares every
// stream byte with a predicted byte. The prediction tracks the string body
// count of the encoder. A short directed list covers the markers, the
// length-prefix boundaries and the error cases. Random value sequences
// follow, with some malformed words mixed in, and then the opening of one
// long string.
// Both handshakes idle at random. One long receiver stall fills the queue.
// ----------------------------------------------------------------------------
module amf3_scalar_value_encoder_tb;

   class amf3_byte_board;
      logic [27:0]        body_left;
      amf3_pkg::rsp_type  due_bytes[$];
      int unsigned        failures;

      function new();
         body_left = '0;
         failures  = 0;
      endfunction

      function void push_byte(logic [7:0] b, logic fin);
         amf3_pkg::rsp_type r;
         r.out_byte = b;
         r.last     = fin;
         r.error    = 1'b0;
         due_bytes.push_back(r);
      endfunction

      function void push_fault();
         amf3_pkg::rsp_type r;
         r.out_byte = '0;
         r.last     = 1'b0;
         r.error    = 1'b1;
         due_bytes.push_back(r);
      endfunction

      function void push_u29(logic [28:0] v, logic fin);
         if (v <= amf3_pkg::U29_LIM1) begin
            push_byte({1'b0, v[6:0]}, fin);
         end else if (v <= amf3_pkg::U29_LIM2) begin
            push_byte({1'b1, v[13:7]}, 1'b0);
            push_byte({1'b0, v[6:0]}, fin);
         end else if (v <= amf3_pkg::U29_LIM3) begin
            push_byte({1'b1, v[20:14]}, 1'b0);
            push_byte({1'b1, v[13:7]}, 1'b0);
            push_byte({1'b0, v[6:0]}, fin);
         end else begin
            push_byte({1'b1, v[28:22]}, 1'b0);
            push_byte({1'b1, v[21:15]}, 1'b0);
            push_byte({1'b1, v[14:8]}, 1'b0);
            push_byte(v[7:0], fin);
         end
      endfunction

      function void push_be64(logic [63:0] v);
         for (int i = 7; i >= 0; i--)
            push_byte(v[i*8 +: 8], i == 0);
      endfunction

      function void note_word(amf3_pkg::req_type w);
         logic [7:0] marker;
         if (w.opcode == amf3_pkg::OP_PAYLOAD) begin
            if (body_left == '0) begin
               push_fault();
            end else begin
               body_left = body_left - 1'b1;
               push_byte(w.payload_byte, body_left == '0);
            end
         end else if (w.opcode > amf3_pkg::OP_PAYLOAD || body_left != '0) begin
            push_fault();
         end else begin
            case (w.opcode)
               amf3_pkg::OP_UNDEF, amf3_pkg::OP_NULL,
               amf3_pkg::OP_FALSE, amf3_pkg::OP_TRUE: push_byte({4'h0, w.opcode}, 1'b1);
               amf3_pkg::OP_INT: begin
                  if (w.value > amf3_pkg::U29_MAX) begin
                     push_fault();
                  end else begin
                     push_byte(amf3_pkg::MK_INT, 1'b0);
                     push_u29(w.value[28:0], 1'b1);
                  end
               end
               amf3_pkg::OP_DOUBLE: begin
                  push_byte(amf3_pkg::MK_DOUBLE, 1'b0);
                  push_be64(w.value);
               end
               amf3_pkg::OP_DATE: begin
                  push_byte(amf3_pkg::MK_DATE, 1'b0);
                  push_byte(amf3_pkg::DATE_FLAG, 1'b0);
                  push_be64(w.value);
               end
               default: begin
                  if (w.value > amf3_pkg::STR_LEN_MAX) begin
                     push_fault();
                  end else begin
                     case (w.opcode)
                        amf3_pkg::OP_STRING: marker = amf3_pkg::MK_STRING;
                        amf3_pkg::OP_XMLDOC: marker = amf3_pkg::MK_XMLDOC;
                        amf3_pkg::OP_XML:    marker = amf3_pkg::MK_XML;
                        default:             marker = amf3_pkg::MK_BYTEARR;
                     endcase
                     push_byte(marker, 1'b0);
                     push_u29({w.value[27:0], 1'b1}, w.value == '0);
                     body_left = w.value[27:0];
                  end
               end
            endcase
         end
      endfunction

      function void check_byte(amf3_pkg::rsp_type got);
         amf3_pkg::rsp_type want;
         if (due_bytes.size() == 0) begin
            $display("%0t: unexpected byte %h last %b error %b", $time,
                     got.out_byte, got.last, got.error);
            failures++;
         end else begin
            want = due_bytes.pop_front();
            if (got.out_byte !== want.out_byte) begin
               $display("%0t: out_byte expected %h, got %h", $time,
                        want.out_byte, got.out_byte);
               failures++;
            end
            if (got.last !== want.last) begin
               $display("%0t: last expected %b, got %b", $time, want.last, got.last);
               failures++;
            end
            if (got.error !== want.error) begin
               $display("%0t: error expected %b, got %b", $time, want.error, got.error);
               failures++;
            end
         end
      endfunction

      function int unsigned backlog();
         return due_bytes.size();
      endfunction
   endclass

   logic              clock;
   logic              reset;
   logic              req_valid;
   logic              req_ready;
   amf3_pkg::req_type req_data;
   logic              rsp_valid;
   logic              rsp_ready;
   amf3_pkg::rsp_type rsp_data;

   amf3_byte_board board;
   bit             hold_off    = 1'b0;
   int unsigned    burst_left  = 0;
   int unsigned    words_sent  = 0;

   amf3_scalar_value_encoder u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   initial clock = 1'b0;
   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   always @(posedge clock) begin
      if (!reset && req_valid && req_ready) board.note_word(req_data);
      if (!reset && rsp_valid && rsp_ready) board.check_byte(rsp_data);
   end

   task automatic send_word(input logic [3:0] op, input logic [63:0] v, input logic [7:0] pb);
      int unsigned       gap;
      amf3_pkg::req_type w;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
         if (gap != 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 24);
      end
      w.opcode       = op;
      w.value        = v;
      w.payload_byte = pb;
      req_valid <= 1'b1;
      req_data  <= w;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      burst_left--;
      words_sent++;
   endtask

   // stray: drop a header into the middle of the body
   task automatic send_string(input logic [3:0] op, input int unsigned len, input bit stray);
      send_word(op, 64'(len), 8'($urandom));
      for (int unsigned i = 0; i < len; i++) begin
         if (stray && i == len / 2)
            send_word(4'($urandom_range(0, 10)), {$urandom, $urandom}, 8'($urandom));
         send_word(amf3_pkg::OP_PAYLOAD, {$urandom, $urandom}, 8'($urandom));
      end
   endtask

   initial begin
      int unsigned cyc;
      rsp_ready = 1'b0;
      cyc = 0;
      forever begin
         @(posedge clock);
         if (hold_off) begin
            rsp_ready <= 1'b0;
            repeat (400) @(posedge clock);
            hold_off = 1'b0;
         end else begin
            case ((cyc >> 7) % 4)
               0: rsp_ready <= 1'b1;
               1: rsp_ready <= 1'($urandom_range(0, 1));
               2: rsp_ready <= (cyc % 8) != 0;
               default: rsp_ready <= $urandom_range(0, 9) > 1;
            endcase
         end
         cyc++;
      end
   end

   initial begin
      #3_200_000;
      $display("FAILED: results differ");
      $finish;
   end

   initial begin
      logic [3:0]  op;
      logic [63:0] v;
      int unsigned len;
      bit          pressed;
      reset     = 1'b1;
      req_valid = 1'b0;
      req_data  = '0;
      pressed   = 1'b0;
      board     = new();
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      send_word(amf3_pkg::OP_UNDEF, '0, '0);
      send_word(amf3_pkg::OP_NULL, '1, '1);
      send_word(amf3_pkg::OP_FALSE, '0, '0);
      send_word(amf3_pkg::OP_TRUE, '0, '0);
      send_word(amf3_pkg::OP_INT, 64'h0, '0);
      send_word(amf3_pkg::OP_INT, 64'h7F, '0);
      send_word(amf3_pkg::OP_INT, 64'h80, '0);
      send_word(amf3_pkg::OP_INT, 64'h3FFF, '0);
      send_word(amf3_pkg::OP_INT, 64'h4000, '0);
      send_word(amf3_pkg::OP_INT, 64'h1F_FFFF, '0);
      send_word(amf3_pkg::OP_INT, 64'h20_0000, '0);
      send_word(amf3_pkg::OP_INT, amf3_pkg::U29_MAX, '0);
      send_word(amf3_pkg::OP_INT, amf3_pkg::U29_MAX + 1, '0);
      send_word(amf3_pkg::OP_DOUBLE, '1, '0);
      send_word(amf3_pkg::OP_DATE, {$urandom, $urandom}, '0);
      send_string(amf3_pkg::OP_STRING, 0, 1'b0);
      send_string(amf3_pkg::OP_XMLDOC, 1, 1'b0);
      send_string(amf3_pkg::OP_XML, 1, 1'b1);
      send_word(amf3_pkg::OP_BYTEARR, amf3_pkg::STR_LEN_MAX + 1, '0);
      send_word(amf3_pkg::OP_PAYLOAD, '0, 8'hA5);
      send_word(4'd12, '0, '0);
      send_word(4'd15, '1, '1);

      while (words_sent < 330) begin
         if (words_sent >= 120 && !pressed) begin
            hold_off = 1'b1;
            pressed  = 1'b1;
         end
         if ($urandom_range(0, 9) < 7) begin
            op = 4'($urandom_range(0, 10));
            case (op)
               amf3_pkg::OP_INT: begin
                  case ($urandom_range(0, 4))
                     0: v = 64'($urandom_range(0, 32'h7F));
                     1: v = 64'($urandom_range(32'h80, 32'h3FFF));
                     2: v = 64'($urandom_range(32'h4000, 32'h1F_FFFF));
                     3: v = 64'($urandom_range(32'h20_0000, 32'h1FFF_FFFF));
                     default: begin
                        v = {$urandom, $urandom};
                        if (v <= amf3_pkg::U29_MAX) v[40] = 1'b1;
                     end
                  endcase
                  send_word(op, v, 8'($urandom));
               end
               amf3_pkg::OP_STRING, amf3_pkg::OP_XMLDOC,
               amf3_pkg::OP_XML, amf3_pkg::OP_BYTEARR: begin
                  len = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 70)
                                                    : $urandom_range(0, 6);
                  send_string(op, len, $urandom_range(0, 15) == 0);
               end
               default: send_word(op, {$urandom, $urandom}, 8'($urandom));
            endcase
         end else begin
            op = 4'($urandom_range(0, 15));
            v  = {$urandom, $urandom};
            if (op >= amf3_pkg::OP_STRING && op <= amf3_pkg::OP_BYTEARR) v[63] = 1'b1;
            send_word(op, v, 8'($urandom));
         end
      end

      len = $urandom_range(8192, 8250);
      send_word(amf3_pkg::OP_BYTEARR, 64'(len), 8'($urandom));
      for (int unsigned i = 0; i < 4; i++)
         send_word(amf3_pkg::OP_PAYLOAD, {$urandom, $urandom}, 8'($urandom));
      send_word(amf3_pkg::OP_TRUE, '0, '0);
      req_valid <= 1'b0;

      while (board.backlog() != 0) @(posedge clock);
      repeat (30) @(posedge clock);
      if (board.failures == 0)
         $display("PASSED: all results match");
      else
         $display("FAILED: results differ");
      $finish;
   end

endmodule
